// ===== src/msps_pkg.sv =====
// Shared types, constants and pin map for the servo PWM scheduler.
package msps_pkg;

   localparam int NUM_SERVOS_DEF = 14;
   localparam int MAX_SERVOS     = 24;
   localparam int WIDTH_W        = 15;
   localparam int COUNT_W        = 16;
   localparam int CHAN_W         = 4;
   localparam int PORT_W         = 8;
   localparam int BIT_W          = 3;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [WIDTH_W-1:0]    NEUTRAL_WIDTH  = 15'd1500;
   localparam logic [COUNT_W-1:0]    DEFAULT_PERIOD = 16'd20000;
   localparam logic [PORT_W-1:0]     ALL_HIGH       = 8'hFF;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD_ADDR = 2'd0;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_ENABLE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PORT_A    = 2'd0,
      PORT_B    = 2'd1,
      PORT_C    = 2'd2,
      PORT_NONE = 2'd3
   } port_type;

   localparam port_type PIN_PORT [MAX_SERVOS] = '{
      PORT_A, PORT_A, PORT_A, PORT_B, PORT_B, PORT_B, PORT_A, PORT_C,
      PORT_C, PORT_B, PORT_C, PORT_C, PORT_A, PORT_B, PORT_NONE, PORT_NONE,
      PORT_NONE, PORT_NONE, PORT_NONE, PORT_NONE, PORT_NONE, PORT_NONE,
      PORT_NONE, PORT_NONE
   };

   localparam logic [BIT_W-1:0] PIN_BIT [MAX_SERVOS] = '{
      3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0,
      3'd1, 3'd3, 3'd6, 3'd7, 3'd6, 3'd7, 3'd0, 3'd0,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
   };

   typedef struct packed {
      logic                  tick;
      logic                  set_enable;
      logic                  enable;
      logic                  cfg_we;
      logic [COUNT_W-1:0]    cfg_period;
   } ctrl_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] period;
      logic               start;
      logic               drive;
   } status_type;

   typedef struct packed {
      logic               valid;
      logic [CHAN_W-1:0]  channel;
      logic [WIDTH_W-1:0] width;
   } wr_type;

   typedef struct packed {
      logic [PORT_W-1:0] a;
      logic [PORT_W-1:0] b;
      logic [PORT_W-1:0] c;
   } ports_type;

endpackage

// ===== src/msps_timebase.sv =====
// Period counter, period register and enable/live tracking.
module msps_timebase (
   input  logic                clock,
   input  logic                reset,
   input  msps_pkg::ctrl_type   ctrl,
   output msps_pkg::status_type status
);
   import msps_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] period_ff, period_in;
   logic               enabled_ff, enabled_in;
   logic               live_ff, live_in;
   logic [COUNT_W:0]   count_inc;
   logic               start;
   logic               drive;

   assign start     = (count_ff == '0);
   assign drive     = live_ff | (start & enabled_ff);
   assign count_inc = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};

   always_comb begin
      count_in   = count_ff;
      period_in  = ctrl.cfg_we ? ctrl.cfg_period : period_ff;
      enabled_in = enabled_ff;
      live_in    = live_ff;
      if (ctrl.tick) begin
         live_in  = drive;
         count_in = (count_inc >= {1'b0, period_ff}) ? '0 : count_inc[COUNT_W-1:0];
      end
      if (ctrl.set_enable) begin
         enabled_in = ctrl.enable;
         if (!ctrl.enable) begin
            live_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         period_ff  <= DEFAULT_PERIOD;
         enabled_ff <= 1'b1;
         live_ff    <= 1'b1;
      end else begin
         count_ff   <= count_in;
         period_ff  <= period_in;
         enabled_ff <= enabled_in;
         live_ff    <= live_in;
      end
   end

   assign status.count  = count_ff;
   assign status.period = period_ff;
   assign status.start  = start;
   assign status.drive  = drive;

`ifndef SYNTH
   a_wrap_at_period: assert property (@(posedge clock) disable iff (reset)
      ctrl.tick && (count_inc >= {1'b0, period_ff}) |=> count_ff == '0)
      else $error("counter did not wrap at period end");
   a_disable_kills_live: assert property (@(posedge clock) disable iff (reset)
      ctrl.set_enable && !ctrl.enable |=> !live_ff && !enabled_ff)
      else $error("disable did not stop driving");
   a_start_drive: assert property (@(posedge clock) disable iff (reset)
      start && enabled_ff |-> drive)
      else $error("enabled period start not driving");
`endif

endmodule

// ===== src/msps_channels.sv =====
// Shadow and active pulse widths with per-channel compares to the counter.
module msps_channels #(
   parameter int NUM_SERVOS = msps_pkg::NUM_SERVOS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick,
   input  msps_pkg::status_type status,
   input  msps_pkg::wr_type     wr,
   output msps_pkg::ports_type  levels
);
   import msps_pkg::*;

   logic [WIDTH_W-1:0] pending_ff [NUM_SERVOS];
   logic [WIDTH_W-1:0] pending_in [NUM_SERVOS];
   logic [WIDTH_W-1:0] active_ff  [NUM_SERVOS];
   logic [WIDTH_W-1:0] active_in  [NUM_SERVOS];
   logic [WIDTH_W-1:0] active_now [NUM_SERVOS];

   always_comb begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
         pending_in[i] = pending_ff[i];
         if (wr.valid && (int'(wr.channel) == i)) begin
            pending_in[i] = wr.width;
         end
         active_now[i] = status.start ? pending_ff[i] : active_ff[i];
         active_in[i]  = tick ? active_now[i] : active_ff[i];
      end
   end

   always_comb begin
      levels.a = ALL_HIGH;
      levels.b = ALL_HIGH;
      levels.c = ALL_HIGH;
      for (int i = 0; i < NUM_SERVOS; i++) begin
         if (status.count >= {1'b0, active_now[i]}) begin
            unique case (PIN_PORT[i])
               PORT_A:    levels.a[PIN_BIT[i]] = 1'b0;
               PORT_B:    levels.b[PIN_BIT[i]] = 1'b0;
               PORT_C:    levels.c[PIN_BIT[i]] = 1'b0;
               PORT_NONE: ;
               default:   ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SERVOS; i++) begin
            pending_ff[i] <= NEUTRAL_WIDTH;
            active_ff[i]  <= NEUTRAL_WIDTH;
         end
      end else begin
         for (int i = 0; i < NUM_SERVOS; i++) begin
            pending_ff[i] <= pending_in[i];
            active_ff[i]  <= active_in[i];
         end
      end
   end

endmodule

// ===== src/multi_servo_pwm_scheduler.sv =====
// Servo PWM scheduler: one tick, width write or enable transaction per clock cycle; each
// accepted transaction yields one port-level transaction through the input register, then
// the compare and result register, and a new one is taken every cycle while rsp_stall is
// low. All NUM_SERVOS width compares against the period counter run in parallel, so the
// rate is one transaction per cycle regardless of period length. Width writes land in
// shadow registers and load at the next period start; period_ticks is at byte address 0.
module multi_servo_pwm_scheduler #(
   parameter int NUM_SERVOS = msps_pkg::NUM_SERVOS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_command,
   input  logic [msps_pkg::CHAN_W-1:0]        req_channel,
   input  logic [msps_pkg::WIDTH_W-1:0]       req_width,
   input  logic                               req_enable,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [msps_pkg::PORT_W-1:0]        rsp_port_a,
   output logic [msps_pkg::PORT_W-1:0]        rsp_port_b,
   output logic [msps_pkg::PORT_W-1:0]        rsp_port_c,
   output logic                               rsp_period_start,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [msps_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [msps_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [msps_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import msps_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [1:0]         cmd_ff;
   logic [CHAN_W-1:0]  channel_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic               enable_ff;
   logic               out_valid_ff, out_valid_in;
   ports_type          out_ports_ff;
   logic               out_start_ff;
   ports_type          held_ff, held_in;
   logic               advance;
   logic               in_load;
   logic               is_tick;
   ctrl_type           ctrl;
   status_type         status;
   wr_type             wr;
   ports_type          levels;

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign in_load   = req_valid & ~req_stall;
   assign is_tick   = advance & (cmd_ff == CMD_TICK);

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_PERIOD_ADDR) ? CSR_DATA_W'(status.period) : '0;

   assign ctrl.tick       = is_tick;
   assign ctrl.set_enable = advance & (cmd_ff == CMD_ENABLE);
   assign ctrl.enable     = enable_ff;
   assign ctrl.cfg_we     = psel & penable & pwrite & pready & (paddr == CSR_PERIOD_ADDR);
   assign ctrl.cfg_period = pwdata[COUNT_W-1:0];

   assign wr.valid   = advance & (cmd_ff == CMD_WRITE);
   assign wr.channel = channel_ff;
   assign wr.width   = width_ff;

   msps_timebase u_timebase (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status)
   );

   msps_channels #(
      .NUM_SERVOS (NUM_SERVOS)
   ) u_channels (
      .clock  (clock),
      .reset  (reset),
      .tick   (is_tick),
      .status (status),
      .wr     (wr),
      .levels (levels)
   );

   always_comb begin
      in_valid_in  = in_load | (in_valid_ff & ~advance);
      held_in      = (is_tick && status.drive) ? levels : held_ff;
      out_valid_in = advance | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_ff      <= '{a: ALL_HIGH, b: ALL_HIGH, c: ALL_HIGH};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         cmd_ff     <= req_command;
         channel_ff <= req_channel;
         width_ff   <= req_width;
         enable_ff  <= req_enable;
      end
      if (advance) begin
         out_ports_ff <= held_in;
         out_start_ff <= is_tick & status.start;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_port_a       = out_ports_ff.a;
   assign rsp_port_b       = out_ports_ff.b;
   assign rsp_port_c       = out_ports_ff.c;
   assign rsp_period_start = out_start_ff;

`ifndef SYNTH
   a_unmapped_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_port_a[5:4] == 2'b11) && rsp_port_a[7] && (rsp_port_b[6:4] == 3'b111)
                    && (rsp_port_c[5:2] == 4'hF))
      else $error("unmapped port bit driven low");
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled with room downstream");
   a_start_only_tick: assert property (@(posedge clock) disable iff (reset)
      advance && (cmd_ff != CMD_TICK) |=> !rsp_period_start)
      else $error("period start flagged on non-tick transaction");
   a_held_only_tick: assert property (@(posedge clock) disable iff (reset)
      !is_tick |=> $stable(held_ff))
      else $error("held ports changed without a tick");
`endif

endmodule

// ===== tb/sv/tb_multi_servo_pwm_scheduler.sv =====
// Self-checking testbench for the multi-channel servo PWM scheduler.
`timescale 1ns / 1ps

module tb_multi_servo_pwm_scheduler;
   import msps_pkg::*;

   localparam int SERVOS = 14;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] port_a;
      logic [7:0] port_b;
      logic [7:0] port_c;
      logic       period_start;
   } port_levels;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  channel;
      logic [14:0] width;
      logic        enable;
   } servo_req;

   class servo_level_tracker;
      logic [15:0] period;
      logic [14:0] pending [SERVOS];
      logic [14:0] active [SERVOS];
      logic [15:0] count;
      logic        drive_on;
      logic        live;
      logic [7:0]  held_a, held_b, held_c;
      port_levels  expected_levels [$];
      int          errors;

      function new();
         period = DEFAULT_PERIOD;
         for (int i = 0; i < SERVOS; i++) begin
            pending[i] = NEUTRAL_WIDTH;
            active[i] = NEUTRAL_WIDTH;
         end
         count = '0;
         drive_on = 1'b1;
         live = 1'b1;
         held_a = ALL_HIGH;
         held_b = ALL_HIGH;
         held_c = ALL_HIGH;
         errors = 0;
      endfunction

      // {port, bit} for each servo
      function logic [4:0] servo_pin(int s);
         case (s)
            0:  return {PORT_A, 3'd0};
            1:  return {PORT_A, 3'd1};
            2:  return {PORT_A, 3'd2};
            3:  return {PORT_B, 3'd0};
            4:  return {PORT_B, 3'd1};
            5:  return {PORT_B, 3'd2};
            6:  return {PORT_A, 3'd3};
            7:  return {PORT_C, 3'd0};
            8:  return {PORT_C, 3'd1};
            9:  return {PORT_B, 3'd3};
            10: return {PORT_C, 3'd6};
            11: return {PORT_C, 3'd7};
            12: return {PORT_A, 3'd6};
            13: return {PORT_B, 3'd7};
            default: return {PORT_NONE, 3'd0};
         endcase
      endfunction

      function void set_period(logic [15:0] value);
         period = value;
      endfunction

      function void apply_command(servo_req item);
         logic        start;
         logic [4:0]  pin;
         logic [7:0]  a, b, c;
         logic [16:0] nxt;
         start = 1'b0;
         case (item.command)
            CMD_WRITE: begin
               if (item.channel < SERVOS) pending[item.channel] = item.width;
            end
            CMD_ENABLE: begin
               drive_on = item.enable;
               if (!item.enable) live = 1'b0;
            end
            CMD_TICK: begin
               start = (count == 16'd0);
               if (start) begin
                  for (int i = 0; i < SERVOS; i++) active[i] = pending[i];
                  if (drive_on) live = 1'b1;
               end
               if (live) begin
                  a = ALL_HIGH;
                  b = ALL_HIGH;
                  c = ALL_HIGH;
                  for (int i = 0; i < SERVOS; i++) begin
                     pin = servo_pin(i);
                     if (count >= {1'b0, active[i]}) begin
                        case (pin[4:3])
                           PORT_A: a[pin[2:0]] = 1'b0;
                           PORT_B: b[pin[2:0]] = 1'b0;
                           PORT_C: c[pin[2:0]] = 1'b0;
                           default: ;
                        endcase
                     end
                  end
                  held_a = a;
                  held_b = b;
                  held_c = c;
               end
               nxt = {1'b0, count} + 17'd1;
               if (nxt >= {1'b0, period}) nxt = '0;
               count = nxt[15:0];
            end
            default: ;
         endcase
         expected_levels.push_back({held_a, held_b, held_c, start});
      endfunction

      function void compare_levels(port_levels got);
         port_levels want;
         if (expected_levels.size() == 0) begin
            $error("unexpected transaction: %h %h %h %b", got.port_a, got.port_b,
                   got.port_c, got.period_start);
            errors++;
            return;
         end
         want = expected_levels.pop_front();
         if (got.port_a !== want.port_a) begin
            $error("port_a expected %h got %h", want.port_a, got.port_a);
            errors++;
         end
         if (got.port_b !== want.port_b) begin
            $error("port_b expected %h got %h", want.port_b, got.port_b);
            errors++;
         end
         if (got.port_c !== want.port_c) begin
            $error("port_c expected %h got %h", want.port_c, got.port_c);
            errors++;
         end
         if (got.period_start !== want.period_start) begin
            $error("period_start expected %b got %b", want.period_start, got.period_start);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic [3:0]  req_channel;
   logic [14:0] req_width;
   logic        req_enable;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_port_a;
   logic [7:0]  rsp_port_b;
   logic [7:0]  rsp_port_c;
   logic        rsp_period_start;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic        pready;

   servo_level_tracker tracker;
   int          idle_pct;
   int          stall_pct;
   int          hold_cycles;

   multi_servo_pwm_scheduler dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_channel(req_channel),
      .req_width(req_width),
      .req_enable(req_enable),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_port_a(rsp_port_a),
      .rsp_port_b(rsp_port_b),
      .rsp_port_c(rsp_port_c),
      .rsp_period_start(rsp_period_start),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("multi_servo_pwm_scheduler regression: fail");
      $finish;
   end

   // result side: check accepted transactions, then pick next stall
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            tracker.compare_levels({rsp_port_a, rsp_port_b, rsp_port_c, rsp_period_start});
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic send_req(servo_req item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_command <= 2'($urandom);
         req_channel <= 4'($urandom);
         req_width <= 15'($urandom);
         req_enable <= 1'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= item.command;
      req_channel <= item.channel;
      req_width <= item.width;
      req_enable <= item.enable;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.apply_command(item);
   endtask

   task automatic send_fields(logic [1:0] cmd, logic [3:0] ch, logic [14:0] w, logic en);
      servo_req item;
      item = {cmd, ch, w, en};
      send_req(item);
   endtask

   // only called while idle: drains results, then writes and reads back the period
   task automatic program_period(logic [15:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_PERIOD_ADDR;
      pwdata <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tracker.set_period(value);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[15:0] !== value) begin
         $error("period_ticks expected %h got %h", value, prdata[15:0]);
         tracker.errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic servo_req random_req(logic [15:0] period);
      servo_req item;
      int r;
      int span;
      item = 22'($urandom);
      r = $urandom_range(99);
      span = (period < 16'd32765) ? int'(period) + 2 : 32767;
      if (r < 60) begin
         item.command = CMD_TICK;
      end else if (r < 84) begin
         item.command = CMD_WRITE;
         item.channel = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                 : 4'($urandom_range(SERVOS - 1));
         item.width = ($urandom_range(7) == 0) ? 15'($urandom_range(32767))
                                               : 15'($urandom_range(span));
      end else if (r < 96) begin
         item.command = CMD_ENABLE;
         item.enable = ($urandom_range(99) < 70);
      end else begin
         item.command = CMD_UNUSED;
      end
      return item;
   endfunction

   int phase_period [8] = '{1, 7, 23, 0, 60, 65535, 3, 120};
   int phase_idle   [8] = '{0, 74, 0, 20, 20, 0, 0, 74};
   int phase_stall  [8] = '{0, 0, 74, 20, 20, 0, 0, 74};
   int phase_items  [8] = '{100, 200, 200, 80, 200, 60, 150, 160};
   int phase_hold   [8] = '{0, 0, 0, 0, 120, 0, 90, 0};

   initial begin
      tracker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_TICK;
      req_channel = '0;
      req_width = '0;
      req_enable = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: width extremes, ignored channels, freeze and late re-enable
      program_period(16'd4);
      send_fields(CMD_TICK, 4'd0, 15'd0, 1'b0);
      send_fields(CMD_TICK, 4'd0, 15'd0, 1'b0);
      send_fields(CMD_WRITE, 4'd0, 15'd0, 1'b0);
      send_fields(CMD_WRITE, 4'd1, 15'd32767, 1'b1);
      send_fields(CMD_WRITE, 4'd2, 15'd2, 1'b0);
      send_fields(CMD_WRITE, 4'd13, 15'd1, 1'b0);
      send_fields(CMD_WRITE, 4'd14, 15'd3, 1'b0);
      send_fields(CMD_WRITE, 4'd15, 15'd0, 1'b1);
      send_fields(CMD_WRITE, 4'd7, 15'd4, 1'b0);
      repeat (5) send_fields(CMD_TICK, 4'd15, 15'd32767, 1'b1);
      send_fields(CMD_ENABLE, 4'd0, 15'd0, 1'b0);
      repeat (2) send_fields(CMD_TICK, 4'd0, 15'd0, 1'b0);
      send_fields(CMD_ENABLE, 4'd0, 15'd0, 1'b1);
      repeat (3) send_fields(CMD_TICK, 4'd0, 15'd0, 1'b0);
      send_fields(CMD_UNUSED, 4'd5, 15'd9, 1'b1);
      send_fields(CMD_TICK, 4'd0, 15'd0, 1'b0);

      for (int p = 0; p < 8; p++) begin
         program_period(16'(phase_period[p]));
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         hold_cycles = phase_hold[p];
         for (int n = 0; n < phase_items[p]; n++)
            send_req(random_req(16'(phase_period[p])));
      end
      program_period(DEFAULT_PERIOD);
      idle_pct = 0;
      stall_pct = 0;
      repeat (6) @(posedge clock);

      if (tracker.errors == 0 && tracker.expected_levels.size() == 0)
         $display("multi_servo_pwm_scheduler regression: pass");
      else
         $display("multi_servo_pwm_scheduler regression: fail");
      $finish;
   end

endmodule
